>>> sv/lcs_pkg.sv
// shared types and codes for the link connection scheduler
`timescale 1ns / 1ps
`default_nettype none
package lcs_pkg;

    typedef enum logic [2:0] {
        K_CONN_REQ = 3'd0,
        K_ADV      = 3'd1,
        K_DISC_REQ = 3'd2,
        K_LINK_UP  = 3'd3,
        K_LINK_DN  = 3'd4,
        K_TICK     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        A_START_SCAN = 3'd0,
        A_STOP_SCAN  = 3'd1,
        A_CONNECT    = 3'd2,
        A_DISCONNECT = 3'd3,
        A_CANCEL     = 3'd4,
        A_STATE      = 3'd5,
        A_ILLEGAL    = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        L_DISC      = 3'd0,
        L_CONN_PARK = 3'd1,
        L_CONNING   = 3'd2,
        L_CONNECTED = 3'd3,
        L_DISC_PARK = 3'd4,
        L_DISCING   = 3'd5
    } t_link;

    typedef enum logic [1:0] {
        M_IDLE   = 2'd0,
        M_CONN   = 2'd1,
        M_DISCON = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        R_DIRECT   = 3'd0,
        R_CTO_EN   = 3'd1,
        R_CTO      = 3'd2,
        R_DTO_EN   = 3'd3,
        R_DTO      = 3'd4,
        R_RETRY_EN = 3'd5,
        R_RETRY    = 3'd6
    } t_reg;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_SCAN_END,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] target;
        logic [2:0] new_link_state;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

>>> sv/lcs_if.sv
// valid/ready channel interfaces for events and results
`timescale 1ns / 1ps
`default_nettype none
interface lcs_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] device;
    modport source (output valid, output kind, output device, input ready);
    modport sink (input valid, input kind, input device, output ready);
endinterface

interface lcs_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] target;
    logic [2:0] new_link_state;
    logic       last;
    modport source (output valid, output action, output target, output new_link_state,
                    output last, input ready);
    modport sink (input valid, input action, input target, input new_link_state,
                  input last, output ready);
endinterface
`default_nettype wire

>>> sv/lcs_cfg.sv
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none
module lcs_cfg
    import lcs_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_psel,
    input  wire        i_penable,
    input  wire        i_pwrite,
    input  wire [4:0]  i_paddr,
    input  wire [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic       o_direct,
    output logic       o_cto_en,
    output logic [15:0] o_cto,
    output logic       o_dto_en,
    output logic [15:0] o_dto,
    output logic       o_retry_en,
    output logic [7:0] o_retry
);
    logic [2:0] w_idx;
    logic       w_hit;
    logic       w_wr;

    assign w_idx = i_paddr[4:2];
    assign w_hit = (i_paddr[1:0] == 2'b00);
    assign w_wr  = i_psel && i_penable && i_pwrite && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_direct   <= 1'b0;
            o_cto_en   <= 1'b0;
            o_cto      <= 16'd1000;
            o_dto_en   <= 1'b0;
            o_dto      <= 16'd1000;
            o_retry_en <= 1'b0;
            o_retry    <= 8'd3;
        end else if (w_wr) begin
            case (t_reg'(w_idx))
                R_DIRECT:   o_direct   <= i_pwdata[0];
                R_CTO_EN:   o_cto_en   <= i_pwdata[0];
                R_CTO:      o_cto      <= i_pwdata[15:0];
                R_DTO_EN:   o_dto_en   <= i_pwdata[0];
                R_DTO:      o_dto      <= i_pwdata[15:0];
                R_RETRY_EN: o_retry_en <= i_pwdata[0];
                R_RETRY:    o_retry    <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = 32'd0;
        if (w_hit) begin
            case (t_reg'(w_idx))
                R_DIRECT:   o_prdata = {31'd0, o_direct};
                R_CTO_EN:   o_prdata = {31'd0, o_cto_en};
                R_CTO:      o_prdata = {16'd0, o_cto};
                R_DTO_EN:   o_prdata = {31'd0, o_dto_en};
                R_DTO:      o_prdata = {16'd0, o_dto};
                R_RETRY_EN: o_prdata = {31'd0, o_retry_en};
                R_RETRY:    o_prdata = {24'd0, o_retry};
                default:    o_prdata = 32'd0;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/link_connection_scheduler_top.sv
// top level of the link connection scheduler
`timescale 1ns / 1ps
`default_nettype none
// The scheduler keeps each device's link state and retry count in one table
// memory (one word per device, registered read) and runs a small sequencer
// over it. An event beat is taken in the idle state, its entry is read in the
// read state, and it is modified and written back in the exec state; the next
// event beat is taken once every result beat has left. A tick that does not
// expire is handled in the idle state. When the handler returns to idle, the
// sequencer sweeps the whole table once to find a device to serve, which is
// then handled through the read and exec states; result beats are held during
// the sweep, since which beat is last is only known at its end. Results are
// queued in a small buffer and drained one beat per cycle while the receiver
// is ready and no sweep runs. After reset the table is swept once to clear it
// before the first event is taken.
module link_connection_scheduler_top
    import lcs_pkg::*;
#(
    parameter int NUM_DEVICES = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lcs_event_if.sink   ev,
    lcs_result_if.source res,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [4:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int CW = $clog2(NUM_DEVICES + 1);
    localparam int QD = 8;

    // configuration
    logic        c_direct, c_cto_en, c_dto_en, c_retry_en;
    logic [15:0] c_cto, c_dto;
    logic [7:0]  c_retry;

    assign pready = 1'b1;

    lcs_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_prdata(prdata),
        .o_direct(c_direct), .o_cto_en(c_cto_en), .o_cto(c_cto),
        .o_dto_en(c_dto_en), .o_dto(c_dto),
        .o_retry_en(c_retry_en), .o_retry(c_retry)
    );

    // table memory: {link state, retry count}
    logic [10:0] mem [NUM_DEVICES];
    logic [10:0] r_rdata;
    logic [AW-1:0] w_raddr, w_waddr;
    logic        w_we;
    logic [10:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    // control state
    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    logic [AW-1:0] r_cur, n_cur;
    logic [15:0] r_timer, n_timer;
    logic        r_trun, n_trun;
    logic [2:0]  r_kind, n_kind;
    logic [3:0]  r_dev, n_dev;
    logic [CW-1:0] r_cnt, n_cnt;    // clear and scan sweep counter
    logic        r_clr, n_clr;
    // scan results
    logic        r_dfound, n_dfound, r_cfound, n_cfound;
    logic [AW-1:0] r_didx, n_didx, r_cidx, n_cidx;
    logic [7:0]  r_cbest, n_cbest;
    logic        r_sval, n_sval;    // a read is returning this cycle in scan
    logic [AW-1:0] r_sidx, n_sidx;

    // result queue
    t_result     r_q [QD];
    logic [3:0]  r_qn, n_qn;
    logic [2:0]  r_qh, n_qh;

    // per-step emit list built in the exec state, or in idle for an illegal event
    t_result     e_list [4];
    logic [2:0]  e_n;

    logic w_dev_ok;
    assign w_dev_ok = ({28'd0, ev.device} < 32'(NUM_DEVICES));

    assign ev.ready = (r_state == S_IDLE) && !r_clr && (r_qn == 4'd0);

    // beats wait during the sweep until the last flag is settled
    assign res.valid          = (r_qn != 4'd0) && (r_state != S_SCAN)
                              && (r_state != S_SCAN_END);
    assign res.action         = r_q[r_qh].action;
    assign res.target         = r_q[r_qh].target;
    assign res.new_link_state = r_q[r_qh].new_link_state;
    assign res.last           = r_q[r_qh].last;

    // combinational helpers on the read word
    logic [2:0] w_ls;
    logic [7:0] w_rc, w_rc_inc;
    logic       w_retry;
    assign w_ls     = r_rdata[10:8];
    assign w_rc     = r_rdata[7:0];
    assign w_rc_inc = c_retry_en ? ((w_rc == 8'hFF) ? w_rc : w_rc + 8'd1) : w_rc;
    assign w_retry  = c_retry_en ? (w_rc_inc < c_retry) : 1'b1;

    logic [3:0] w_dev4;
    logic [3:0] w_cur4;
    assign w_cur4 = 4'(r_cur);

    function automatic t_result mk(input t_action a, input logic [3:0] t,
                                   input logic [2:0] s);
        t_result x;
        x.action = a;
        x.target = t;
        x.new_link_state = s;
        x.last = 1'b0;
        return x;
    endfunction

    // flags set by exec for chaining
    logic e_go_idle, e_conn, e_disc;

    always_comb begin
        n_state = r_state; n_mode = r_mode; n_cur = r_cur; n_timer = r_timer;
        n_trun = r_trun; n_kind = r_kind; n_dev = r_dev; n_cnt = r_cnt; n_clr = r_clr;
        n_dfound = r_dfound; n_cfound = r_cfound; n_didx = r_didx; n_cidx = r_cidx;
        n_cbest = r_cbest; n_sval = 1'b0; n_sidx = r_sidx;
        w_raddr = AW'(r_dev); w_waddr = AW'(r_dev); w_we = 1'b0; w_wdata = r_rdata;
        e_n = 3'd0;
        for (int i = 0; i < 4; i++) e_list[i] = mk(A_START_SCAN, 4'd0, 3'd0);
        e_go_idle = 1'b0; e_conn = 1'b0; e_disc = 1'b0;
        w_dev4 = r_dev;

        case (r_state)
            S_IDLE: begin
                if (r_clr) begin
                    w_we = 1'b1; w_waddr = AW'(r_cnt); w_wdata = 11'd0;
                    n_cnt = r_cnt + CW'(1);
                    if (r_cnt == CW'(NUM_DEVICES - 1)) n_clr = 1'b0;
                end else if (ev.valid && ev.ready) begin
                    n_kind = ev.kind; n_dev = ev.device;
                    if (ev.kind == K_TICK) begin
                        if (r_trun) begin
                            if (r_timer <= 16'd1) begin
                                n_trun = 1'b0; n_timer = 16'd0;
                                if (r_mode != M_IDLE) begin
                                    n_dev = w_cur4; n_state = S_READ;
                                end
                            end else begin
                                n_timer = r_timer - 16'd1;
                            end
                        end
                    end else if (ev.kind > K_TICK || !w_dev_ok) begin
                        e_list[0] = mk(A_ILLEGAL, ev.device, 3'd0); e_n = 3'd1;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                w_raddr = AW'(r_dev);
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // one event or timeout applied to the entry in r_rdata
                w_waddr = AW'(r_dev);
                if (r_kind == K_TICK) begin
                    if (r_mode == M_CONN) begin
                        e_list[0] = mk(A_CANCEL, w_dev4, 3'd0);
                        e_list[1] = mk(A_STATE, w_dev4, w_retry ? L_CONN_PARK : L_DISC);
                        e_n = 3'd2; w_we = 1'b1;
                        w_wdata = {w_retry ? L_CONN_PARK : L_DISC, w_rc_inc};
                    end else begin
                        e_list[0] = mk(A_STATE, w_dev4, L_DISC); e_n = 3'd1;
                        w_we = 1'b1; w_wdata = {L_DISC, w_rc};
                    end
                    e_go_idle = 1'b1;
                end else begin
                    case (r_mode)
                        M_CONN: begin
                            case (t_kind'(r_kind))
                                K_CONN_REQ: begin
                                    if (w_dev4 != w_cur4) begin
                                        if (w_ls == L_DISC) begin
                                            e_list[0] = mk(A_STATE, w_dev4, L_CONN_PARK);
                                            e_n = 3'd1; w_we = 1'b1; w_wdata = {L_CONN_PARK, w_rc};
                                        end else if (w_ls == L_DISC_PARK) begin
                                            e_list[0] = mk(A_STATE, w_dev4, L_CONNECTED);
                                            e_n = 3'd1; w_we = 1'b1; w_wdata = {L_CONNECTED, w_rc};
                                        end
                                    end
                                end
                                K_ADV: ;
                                K_DISC_REQ: begin
                                    if (w_dev4 == w_cur4) begin
                                        e_list[0] = mk(A_CANCEL, w_dev4, 3'd0);
                                        e_list[1] = mk(A_STATE, w_dev4, L_DISC);
                                        e_n = 3'd2; w_we = 1'b1; w_wdata = {L_DISC, w_rc};
                                        e_go_idle = 1'b1;
                                    end else if (w_ls == L_CONNECTED) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_DISC_PARK);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_DISC_PARK, w_rc};
                                    end else if (w_ls == L_CONN_PARK) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_DISC);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_DISC, w_rc};
                                    end else begin
                                        e_list[0] = mk(A_ILLEGAL, w_dev4, 3'd0); e_n = 3'd1;
                                    end
                                end
                                K_LINK_UP: begin
                                    if (w_dev4 == w_cur4) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_CONNECTED);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_CONNECTED, w_rc};
                                        e_go_idle = 1'b1;
                                    end else begin
                                        e_list[0] = mk(A_ILLEGAL, w_dev4, 3'd0); e_n = 3'd1;
                                    end
                                end
                                default: begin
                                    w_we = 1'b1;
                                    w_wdata = {w_retry ? L_CONN_PARK : L_DISC, w_rc_inc};
                                    e_list[0] = mk(A_STATE, w_dev4,
                                                   w_retry ? L_CONN_PARK : L_DISC);
                                    e_n = 3'd1;
                                    if (w_dev4 == w_cur4) e_go_idle = 1'b1;
                                    else if (w_retry) begin
                                        e_list[1] = mk(A_START_SCAN, 4'd0, 3'd0); e_n = 3'd2;
                                    end
                                end
                            endcase
                        end
                        M_DISCON: begin
                            case (t_kind'(r_kind))
                                K_CONN_REQ: begin
                                    if (w_ls == L_DISC_PARK || w_ls == L_DISC ||
                                        w_ls == L_DISCING) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_CONN_PARK);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_CONN_PARK, w_rc};
                                    end
                                end
                                K_ADV: ;
                                K_DISC_REQ: begin
                                    if (w_ls == L_CONNECTED) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_DISC_PARK);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_DISC_PARK, w_rc};
                                    end else if (w_ls == L_CONN_PARK) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_DISC);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_DISC, w_rc};
                                    end else begin
                                        e_list[0] = mk(A_ILLEGAL, w_dev4, 3'd0); e_n = 3'd1;
                                    end
                                end
                                K_LINK_UP: begin
                                    e_list[0] = mk(A_ILLEGAL, w_dev4, 3'd0); e_n = 3'd1;
                                end
                                default: begin
                                    w_we = 1'b1; e_n = 3'd1;
                                    if (w_dev4 == w_cur4) begin
                                        w_wdata = {L_DISC, w_rc};
                                        e_list[0] = mk(A_STATE, w_dev4, L_DISC);
                                        e_go_idle = 1'b1;
                                    end else begin
                                        w_wdata = {w_retry ? L_CONN_PARK : L_DISC, w_rc_inc};
                                        e_list[0] = mk(A_STATE, w_dev4,
                                                       w_retry ? L_CONN_PARK : L_DISC);
                                    end
                                end
                            endcase
                        end
                        default: begin
                            case (t_kind'(r_kind))
                                K_CONN_REQ: begin
                                    if (w_ls == L_DISC) begin
                                        if (!c_direct) begin
                                            e_list[0] = mk(A_START_SCAN, 4'd0, 3'd0);
                                            e_list[1] = mk(A_STATE, w_dev4, L_CONN_PARK);
                                            e_n = 3'd2; w_we = 1'b1;
                                            w_wdata = {L_CONN_PARK, w_rc};
                                        end else e_conn = 1'b1;
                                    end else if (w_ls == L_DISC_PARK) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_CONNECTED);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_CONNECTED, w_rc};
                                    end
                                end
                                K_ADV: begin
                                    if (w_ls == L_CONN_PARK) e_conn = 1'b1;
                                end
                                K_DISC_REQ: begin
                                    // a disconnect-parked entry only gets here from the sweep
                                    if (w_ls == L_CONNECTED || w_ls == L_DISC_PARK)
                                        e_disc = 1'b1;
                                    else if (w_ls == L_CONN_PARK) begin
                                        e_list[0] = mk(A_STATE, w_dev4, L_DISC);
                                        e_n = 3'd1; w_we = 1'b1; w_wdata = {L_DISC, w_rc};
                                    end else if (w_ls != L_DISC) begin
                                        e_list[0] = mk(A_ILLEGAL, w_dev4, 3'd0); e_n = 3'd1;
                                    end
                                end
                                K_LINK_DN: begin
                                    w_we = 1'b1;
                                    if (w_retry) begin
                                        if (!c_direct) begin
                                            w_wdata = {L_CONN_PARK, w_rc_inc};
                                            e_list[0] = mk(A_STATE, w_dev4, L_CONN_PARK);
                                            e_n = 3'd1;
                                        end else begin
                                            w_wdata = {L_CONNING, w_rc_inc};
                                            e_conn = 1'b1;
                                        end
                                    end else begin
                                        w_wdata = {L_DISC, w_rc_inc};
                                        e_list[0] = mk(A_STATE, w_dev4, L_DISC); e_n = 3'd1;
                                    end
                                end
                                default: begin
                                    e_list[0] = mk(A_ILLEGAL, w_dev4, 3'd0); e_n = 3'd1;
                                end
                            endcase
                        end
                    endcase
                end
                // mode chaining
                if (e_conn || e_disc) begin
                    if (r_mode == M_CONN) begin
                        e_list[e_n[1:0]] = mk(A_START_SCAN, 4'd0, 3'd0);
                        e_n = e_n + 3'd1;
                    end
                    n_trun = 1'b0; n_timer = 16'd0;
                    n_cur = AW'(r_dev); w_we = 1'b1;
                    if (e_conn) begin
                        n_mode = M_CONN;
                        e_list[e_n[1:0]] = mk(A_STOP_SCAN, 4'd0, 3'd0);
                        e_list[e_n[1:0] + 2'd1] = mk(A_CONNECT, w_dev4, 3'd0);
                        e_list[e_n[1:0] + 2'd2] = mk(A_STATE, w_dev4, L_CONNING);
                        e_n = e_n + 3'd3;
                        w_wdata = {L_CONNING, w_wdata[7:0]};
                        if (c_cto_en) begin n_timer = c_cto; n_trun = 1'b1; end
                    end else begin
                        n_mode = M_DISCON;
                        e_list[e_n[1:0]] = mk(A_DISCONNECT, w_dev4, 3'd0);
                        e_list[e_n[1:0] + 2'd1] = mk(A_STATE, w_dev4, L_DISCING);
                        e_n = e_n + 3'd2;
                        w_wdata = {L_DISCING, w_wdata[7:0]};
                        if (c_dto_en) begin n_timer = c_dto; n_trun = 1'b1; end
                    end
                    n_state = S_EMIT;
                end else if (e_go_idle) begin
                    if (r_mode == M_CONN) begin
                        e_list[e_n[1:0]] = mk(A_START_SCAN, 4'd0, 3'd0);
                        e_n = e_n + 3'd1;
                    end
                    n_trun = 1'b0; n_timer = 16'd0; n_mode = M_IDLE;
                    n_cnt = '0; n_dfound = 1'b0; n_cfound = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                // sweep the table, one read per cycle; data returns in the following cycle
                w_raddr = AW'(r_cnt);
                n_sidx = AW'(r_cnt);
                if (r_cnt < CW'(NUM_DEVICES)) begin
                    n_sval = 1'b1; n_cnt = r_cnt + CW'(1);
                end
                if (r_sval) begin
                    if (w_ls == L_DISC_PARK && !r_dfound) begin
                        n_dfound = 1'b1; n_didx = r_sidx;
                    end
                    if (w_ls == L_CONN_PARK && (!r_cfound || w_rc < r_cbest)) begin
                        n_cfound = 1'b1; n_cidx = r_sidx; n_cbest = w_rc;
                    end
                end
                if (!r_sval && r_cnt == CW'(NUM_DEVICES)) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                // chosen entry is re-read into r_rdata via S_READ/S_EXEC path
                if (r_dfound || (c_direct && r_cfound)) begin
                    n_dev = 4'(r_dfound ? r_didx : r_cidx);
                    n_kind = r_dfound ? K_DISC_REQ : K_ADV;
                    n_state = S_READ;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_qn == 4'd0) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // chained service from the sweep: mode is idle and the chosen entry is
    // parked, so the idle rules for advertisement / disconnect request start
    // the new mode

    // queue push and drain
    logic w_pop;
    logic w_final;
    assign w_pop = res.valid && res.ready;
    // last marks the end of the whole event's results
    assign w_final = (r_state == S_EXEC && !e_go_idle)
                   || (r_state == S_IDLE && e_n != 3'd0);
    logic w_end_empty;
    assign w_end_empty = (r_state == S_SCAN_END) && !(r_dfound || (c_direct && r_cfound));

    t_result w_push [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_push[i] = e_list[i];
            if (w_final && 3'(i) == e_n - 3'd1) w_push[i].last = 1'b1;
        end
    end

    always_comb begin
        n_qn = r_qn - (w_pop ? 4'd1 : 4'd0) + 4'(e_n);
        n_qh = r_qh + (w_pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < e_n)
                r_q[3'(r_qh + 3'(r_qn) + 3'(i))] <= w_push[i];
        end
        // sweep found nothing: flag the newest queued beat as last
        if (w_end_empty && r_qn != 4'd0)
            r_q[3'(r_qh + 3'(r_qn) - 3'd1)].last <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= M_IDLE; r_cur <= '0; r_timer <= 16'd0;
            r_trun <= 1'b0; r_kind <= 3'd0; r_dev <= 4'd0; r_cnt <= '0; r_clr <= 1'b1;
            r_dfound <= 1'b0; r_cfound <= 1'b0; r_didx <= '0; r_cidx <= '0;
            r_cbest <= 8'd0; r_sval <= 1'b0; r_sidx <= '0; r_qn <= 4'd0; r_qh <= 3'd0;
        end else begin
            r_state <= n_state; r_mode <= n_mode; r_cur <= n_cur; r_timer <= n_timer;
            r_trun <= n_trun; r_kind <= n_kind; r_dev <= n_dev; r_cnt <= n_cnt;
            r_clr <= n_clr; r_dfound <= n_dfound; r_cfound <= n_cfound;
            r_didx <= n_didx; r_cidx <= n_cidx; r_cbest <= n_cbest; r_sval <= n_sval;
            r_sidx <= n_sidx; r_qn <= n_qn; r_qh <= n_qh;
        end
    end

    // assertions
    a_qbound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_qn <= 4'(QD))
        else $error("result queue overflow");
    a_noacc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qn != 4'd0) |-> !ev.ready)
        else $error("event accepted with results pending");
    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_IDLE && r_state == S_IDLE) |-> !r_trun)
        else $error("timer running in idle");
endmodule
`default_nettype wire

>>> verif/link_connection_scheduler_top_test.sv
// self-checking regression for the link connection scheduler top level
`timescale 1ns / 1ps
`default_nettype none
module link_connection_scheduler_top_test;
    import lcs_pkg::*;

    localparam int NDEV = 16;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire [31:0] prdata;
    wire pready;

    lcs_event_if ev_ch ();
    lcs_result_if res_ch ();

    link_connection_scheduler_top #(.NUM_DEVICES(NDEV)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .ev      (ev_ch.sink),
        .res     (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the scheduler: registers, handler mode and device table
    logic        sh_direct;
    logic        sh_cto_en;
    logic [15:0] sh_cto;
    logic        sh_dto_en;
    logic [15:0] sh_dto;
    logic        sh_retry_en;
    logic [7:0]  sh_retry_lim;
    t_mode       sh_mode;
    logic [3:0]  sh_cur;
    t_link       sh_link [NDEV];
    logic [7:0]  sh_retries [NDEV];
    logic [15:0] sh_timer;
    logic        sh_timer_on;

    t_result pending_results [$];
    t_result step_out [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit timed_out = 1'b0;

    // ---------------- predictor ----------------

    function automatic void put(t_action a, logic [3:0] t, t_link s);
        t_result r;
        if (step_out.size() < 8) begin
            r.action = a;
            r.target = t;
            r.new_link_state = s;
            r.last = 1'b0;
            step_out = {step_out, r};
        end
    endfunction

    function automatic void set_link_state(logic [3:0] d, t_link s);
        sh_link[d] = s;
        put(A_STATE, d, s);
    endfunction

    // bumps the retry count (saturating) when limiting is on
    function automatic bit may_retry(logic [3:0] d);
        if (!sh_retry_en) return 1'b1;
        if (sh_retries[d] != 8'hff) sh_retries[d]++;
        return sh_retries[d] < sh_retry_lim;
    endfunction

    function automatic void quit_mode();
        if (sh_mode == M_CONN) begin
            sh_timer_on = 1'b0;
            sh_timer = '0;
            put(A_START_SCAN, 4'd0, L_DISC);
        end else if (sh_mode == M_DISCON) begin
            sh_timer_on = 1'b0;
            sh_timer = '0;
        end
    endfunction

    function automatic void go_connecting(logic [3:0] d);
        quit_mode();
        sh_mode = M_CONN;
        put(A_STOP_SCAN, 4'd0, L_DISC);
        sh_cur = d;
        put(A_CONNECT, d, L_DISC);
        set_link_state(d, L_CONNING);
        if (sh_cto_en) begin
            sh_timer = sh_cto;
            sh_timer_on = 1'b1;
        end
    endfunction

    function automatic void go_disconnecting(logic [3:0] d);
        quit_mode();
        sh_mode = M_DISCON;
        sh_cur = d;
        put(A_DISCONNECT, d, L_DISC);
        set_link_state(d, L_DISCING);
        if (sh_dto_en) begin
            sh_timer = sh_dto;
            sh_timer_on = 1'b1;
        end
    endfunction

    // idle entry: disconnect-parked first, then in direct mode the fewest-retry connect-park
    function automatic void go_idle();
        int best;
        bit found;
        best = 0;
        found = 1'b0;
        quit_mode();
        sh_mode = M_IDLE;
        for (int i = 0; i < NDEV; i++)
            if (sh_link[i] == L_DISC_PARK) begin
                go_disconnecting(4'(i));
                return;
            end
        if (!sh_direct) return;
        for (int i = 0; i < NDEV; i++)
            if (sh_link[i] == L_CONN_PARK && (!found || sh_retries[i] < sh_retries[best])) begin
                best = i;
                found = 1'b1;
            end
        if (found) go_connecting(4'(best));
    endfunction

    function automatic void timeout_fired();
        logic [3:0] d;
        d = sh_cur;
        if (sh_mode == M_CONN) begin
            put(A_CANCEL, d, L_DISC);
            set_link_state(d, may_retry(d) ? L_CONN_PARK : L_DISC);
            go_idle();
        end else if (sh_mode == M_DISCON) begin
            set_link_state(d, L_DISC);
            go_idle();
        end
    endfunction

    function automatic void in_idle(logic [2:0] k, logic [3:0] d);
        t_link s;
        s = sh_link[d];
        case (k)
            K_CONN_REQ: begin
                if (s == L_DISC) begin
                    if (!sh_direct) begin
                        put(A_START_SCAN, 4'd0, L_DISC);
                        set_link_state(d, L_CONN_PARK);
                    end else go_connecting(d);
                end else if (s == L_DISC_PARK) set_link_state(d, L_CONNECTED);
            end
            K_ADV: if (s == L_CONN_PARK) go_connecting(d);
            K_DISC_REQ: begin
                if (s == L_CONNECTED) go_disconnecting(d);
                else if (s == L_CONN_PARK) set_link_state(d, L_DISC);
                else if (s != L_DISC) put(A_ILLEGAL, d, L_DISC);
            end
            K_LINK_DN: begin
                if (may_retry(d)) begin
                    if (!sh_direct) set_link_state(d, L_CONN_PARK);
                    else go_connecting(d);
                end else set_link_state(d, L_DISC);
            end
            default: put(A_ILLEGAL, d, L_DISC);
        endcase
    endfunction

    function automatic void in_connecting(logic [2:0] k, logic [3:0] d);
        t_link s;
        bit cur;
        s = sh_link[d];
        cur = (d == sh_cur);
        case (k)
            K_CONN_REQ: if (!cur) begin
                if (s == L_DISC) set_link_state(d, L_CONN_PARK);
                else if (s == L_DISC_PARK) set_link_state(d, L_CONNECTED);
            end
            K_ADV: ;
            K_DISC_REQ: begin
                if (cur) begin
                    put(A_CANCEL, d, L_DISC);
                    set_link_state(d, L_DISC);
                    go_idle();
                end else if (s == L_CONNECTED) set_link_state(d, L_DISC_PARK);
                else if (s == L_CONN_PARK) set_link_state(d, L_DISC);
                else put(A_ILLEGAL, d, L_DISC);
            end
            K_LINK_UP: begin
                if (cur) begin
                    set_link_state(d, L_CONNECTED);
                    go_idle();
                end else put(A_ILLEGAL, d, L_DISC);
            end
            default: begin
                if (cur) begin
                    set_link_state(d, may_retry(d) ? L_CONN_PARK : L_DISC);
                    go_idle();
                end else if (may_retry(d)) begin
                    set_link_state(d, L_CONN_PARK);
                    put(A_START_SCAN, 4'd0, L_DISC);
                end else set_link_state(d, L_DISC);
            end
        endcase
    endfunction

    function automatic void in_disconnecting(logic [2:0] k, logic [3:0] d);
        t_link s;
        s = sh_link[d];
        case (k)
            K_CONN_REQ:
                if (s == L_DISC_PARK || s == L_DISC || s == L_DISCING)
                    set_link_state(d, L_CONN_PARK);
            K_ADV: ;
            K_DISC_REQ: begin
                if (s == L_CONNECTED) set_link_state(d, L_DISC_PARK);
                else if (s == L_CONN_PARK) set_link_state(d, L_DISC);
                else put(A_ILLEGAL, d, L_DISC);
            end
            K_LINK_UP: put(A_ILLEGAL, d, L_DISC);
            default: begin
                if (d == sh_cur) begin
                    set_link_state(d, L_DISC);
                    go_idle();
                end else set_link_state(d, may_retry(d) ? L_CONN_PARK : L_DISC);
            end
        endcase
    endfunction

    // predicts the result beats of one event and queues them
    function automatic void predict_event(logic [2:0] k, logic [3:0] d);
        step_out.delete();
        if (k == K_TICK) begin
            if (sh_timer_on) begin
                if (sh_timer <= 16'd1) begin
                    sh_timer_on = 1'b0;
                    sh_timer = '0;
                    timeout_fired();
                end else sh_timer--;
            end
        end else if (k > K_TICK) put(A_ILLEGAL, d, L_DISC);
        else if (sh_mode == M_CONN) in_connecting(k, d);
        else if (sh_mode == M_DISCON) in_disconnecting(k, d);
        else in_idle(k, d);
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        pending_results = {pending_results, step_out};
    endfunction

    // ---------------- drivers ----------------

    // valid stays high after a beat until the next call or a drain drops it
    task automatic send_event(logic [2:0] k, logic [3:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            ev_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.kind <= k;
        ev_ch.device <= d;
        @(posedge i_clk);
        while (!ev_ch.ready) @(posedge i_clk);
        predict_event(k, d);
    endtask

    // psel stays high between back-to-back writes; configure drops it
    task automatic write_reg(t_reg r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(r) << 2;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (r)
            R_DIRECT:   sh_direct = v[0];
            R_CTO_EN:   sh_cto_en = v[0];
            R_CTO:      sh_cto = v[15:0];
            R_DTO_EN:   sh_dto_en = v[0];
            R_DTO:      sh_dto = v[15:0];
            R_RETRY_EN: sh_retry_en = v[0];
            R_RETRY:    sh_retry_lim = v[7:0];
            default: ;
        endcase
    endtask

    // waits until every predicted beat has been seen, then a settle pause
    task automatic drain();
        ev_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(bit dm, bit cen, logic [15:0] ct, bit den, logic [15:0] dt,
                             bit ren, logic [7:0] rl);
        drain();
        write_reg(R_DIRECT, 32'(dm));
        write_reg(R_CTO_EN, 32'(cen));
        write_reg(R_CTO, 32'(ct));
        write_reg(R_DTO_EN, 32'(den));
        write_reg(R_DTO, 32'(dt));
        write_reg(R_RETRY_EN, 32'(ren));
        write_reg(R_RETRY, 32'(rl));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // receiver: random back-pressure, compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.action = res_ch.action;
            got.target = res_ch.target;
            got.new_link_state = res_ch.new_link_state;
            got.last = res_ch.last;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel and no register access
    always @(posedge i_clk) begin
        if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("link_connection_scheduler_top regression: fail");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // connect flow without direct mode: park, advertisement, link up, disconnect, link down, illegal kinds, a tick
    task automatic test_scan_flow();
        send_event(K_CONN_REQ, 4'd0);
        send_event(K_CONN_REQ, 4'd15);
        send_event(K_ADV, 4'd15);
        send_event(K_CONN_REQ, 4'd1);
        send_event(K_LINK_UP, 4'd3);
        send_event(K_LINK_UP, 4'd15);
        send_event(K_DISC_REQ, 4'd15);
        send_event(K_CONN_REQ, 4'd15);
        send_event(K_LINK_DN, 4'd15);
        send_event(K_LINK_UP, 4'd0);
        send_event(K_DISC_REQ, 4'd1);
        send_event(3'd6, 4'd9);
        send_event(3'd7, 4'd6);
        send_event(K_TICK, 4'd0);
    endtask

    // direct mode with short timeouts and retry limits
    task automatic test_direct_timeouts();
        configure(1'b1, 1'b1, 16'd1, 1'b1, 16'd2, 1'b1, 8'd2);
        send_event(K_CONN_REQ, 4'd5);
        send_event(K_TICK, 4'd0);
        send_event(K_TICK, 4'd0);
        send_event(K_LINK_DN, 4'd5);
        send_event(K_LINK_UP, 4'd5);
        send_event(K_DISC_REQ, 4'd5);
        send_event(K_TICK, 4'd0);
        send_event(K_TICK, 4'd0);
        send_event(K_LINK_DN, 4'd10);
        send_event(K_TICK, 4'd0);
    endtask

    // mostly well-formed link sequences over a few devices, some noise
    task automatic test_random(int count);
        logic [2:0] k;
        logic [3:0] d;
        for (int n = 0; n < count; n++) begin
            d = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(3));
            if ($urandom_range(19) == 0) k = 3'($urandom_range(7));
            else k = 3'($urandom_range(5));
            send_event(k, d);
        end
    endtask

    initial begin
        ev_ch.valid = 1'b0;
        ev_ch.kind = '0;
        ev_ch.device = '0;
        sh_direct = 1'b0;
        sh_cto_en = 1'b0;
        sh_cto = 16'd1000;
        sh_dto_en = 1'b0;
        sh_dto = 16'd1000;
        sh_retry_en = 1'b0;
        sh_retry_lim = 8'd3;
        sh_mode = M_IDLE;
        sh_cur = '0;
        sh_timer = '0;
        sh_timer_on = 1'b0;
        for (int i = 0; i < NDEV; i++) begin
            sh_link[i] = L_DISC;
            sh_retries[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_scan_flow();
        test_direct_timeouts();

        send_idle_pct = 24;
        recv_idle_pct = 46;
        configure(1'b0, 1'b1, 16'd3, 1'b1, 16'd65535, 1'b1, 8'd255);
        test_random(110);
        send_idle_pct = 46;
        recv_idle_pct = 24;
        configure(1'b1, 1'b1, 16'd65535, 1'b1, 16'd4, 1'b1, 8'd0);
        test_random(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(1'b1, 1'b0, 16'd2, 1'b0, 16'd1, 1'b0, 8'd3);
        test_random(110);
        drain();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("link_connection_scheduler_top regression: pass");
        else
            $display("link_connection_scheduler_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
